[rtl/core/dq_pkg.sv]
package dq_pkg;

    // Default sizing
    localparam int DQ_CAPACITY   = 64;
    localparam int DQ_DATA_WIDTH = 32;

    // Fixed field widths of the request and response
    localparam int OP_W    = 3;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] data_value;
    } dq_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [WORD_W-1:0]  front_value;
        logic [WORD_W-1:0]  back_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               is_full;
    } dq_rsp_t;

endpackage

[rtl/core/dq_ram.sv]
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/dq_ctrl.sv]
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int CAPACITY   = DQ_CAPACITY,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  dq_req_t                     req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output dq_rsp_t                     rsp,
    output logic                        ram_wr_en,
    output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
    output logic [DATA_WIDTH-1:0]       ram_wr_data,
    output logic                        ram_rd_en,
    output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]       ram_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM  = SW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  rev_reg, rev_next;
    logic [DATA_WIDTH-1:0] low_reg, low_next;
    logic [DATA_WIDTH-1:0] high_reg, high_next;
    logic                  pend_low_reg, pend_low_next;
    logic                  out_valid_reg, out_valid_next;
    dq_rsp_t               out_reg, out_next;

    logic                  out_free;
    logic                  accept;
    logic                  load_out;
    logic [STAT_W-1:0]     status;
    logic                  is_push, is_pop, push_low, pop_low;
    logic                  full, empty;
    logic [SW-1:0]         head_sum, cnt_sum;
    logic [AW-1:0]         idx_before, idx_after, idx_tail, idx_prev;
    logic [DATA_WIDTH-1:0] push_word;
    logic [DATA_WIDTH-1:0] front_word, back_word;
    logic [WORD_W-1:0]     front_field, back_field;
    logic [COUNT_W-1:0]    count_field;

    function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        d = s - CAP_SUM;
        return (s >= CAP_SUM) ? d[AW-1:0] : s[AW-1:0];
    endfunction

    // Width adaptation between the fixed 32-bit fields and the stored word
    if (DATA_WIDTH >= WORD_W)
    begin : g_wide
        assign push_word   = DATA_WIDTH'(req.data_value);
        assign front_field = front_word[WORD_W-1:0];
        assign back_field  = back_word[WORD_W-1:0];
    end
    else
    begin : g_narrow
        assign push_word   = req.data_value[DATA_WIDTH-1:0];
        assign front_field = WORD_W'(front_word);
        assign back_field  = WORD_W'(back_word);
    end

    if (CW >= COUNT_W)
    begin : g_cnt_wide
        assign count_field = count_next[COUNT_W-1:0];
    end
    else
    begin : g_cnt_narrow
        assign count_field = COUNT_W'(count_next);
    end

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;

    assign is_push  = (req.op == OP_PUSH_FRONT) || (req.op == OP_PUSH_BACK);
    assign is_pop   = (req.op == OP_POP_FRONT) || (req.op == OP_POP_BACK);
    assign push_low = (req.op == OP_PUSH_FRONT) != rev_reg;
    assign pop_low  = (req.op == OP_POP_FRONT) != rev_reg;
    assign full     = (count_reg == CAP_CNT);
    assign empty    = (count_reg == '0);

    assign head_sum   = SW'(head_reg);
    assign cnt_sum    = SW'(count_reg);
    assign idx_before = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign idx_after  = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign idx_tail   = ring_wrap(head_sum + cnt_sum);
    // only used when at least three words are held
    assign idx_prev   = ring_wrap(head_sum + cnt_sum - SW'(2));

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        rev_next      = rev_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        pend_low_next = pend_low_reg;
        load_out      = 1'b0;
        status        = STAT_DONE;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_tail;
        ram_wr_data   = push_word;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = idx_after;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    if (is_push)
                    begin
                        if (full)
                        begin
                            status = STAT_FULL;
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (push_low)
                            begin
                                head_next   = idx_before;
                                ram_wr_addr = idx_before;
                                low_next    = push_word;
                                if (empty)
                                begin
                                    high_next = push_word;
                                end
                            end
                            else
                            begin
                                high_next = push_word;
                                if (empty)
                                begin
                                    low_next = push_word;
                                end
                            end
                        end
                    end
                    else if (is_pop)
                    begin
                        if (empty)
                        begin
                            status = STAT_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (pop_low)
                            begin
                                head_next = idx_after;
                            end
                            if (count_reg == CW'(2))
                            begin
                                // one word left: both ends are that word
                                if (pop_low)
                                begin
                                    low_next = high_reg;
                                end
                                else
                                begin
                                    high_next = low_reg;
                                end
                            end
                            else if (count_reg > CW'(2))
                            begin
                                // new end word must be fetched from the ring
                                load_out      = 1'b0;
                                ram_rd_en     = 1'b1;
                                ram_rd_addr   = pop_low ? idx_after : idx_prev;
                                pend_low_next = pop_low;
                                state_next    = ST_READ;
                            end
                        end
                    end
                    else if (req.op == OP_REVERSE)
                    begin
                        rev_next = !rev_reg;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (pend_low_reg)
                    begin
                        low_next = ram_rd_data;
                    end
                    else
                    begin
                        high_next = ram_rd_data;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (count_next == '0)
        begin
            front_word = '0;
            back_word  = '0;
        end
        else if (rev_next)
        begin
            front_word = high_next;
            back_word  = low_next;
        end
        else
        begin
            front_word = low_next;
            back_word  = high_next;
        end
        out_next.status      = status;
        out_next.front_value = front_field;
        out_next.back_value  = back_field;
        out_next.entry_count = count_field;
        out_next.is_empty    = (count_next == '0);
        out_next.is_full     = (count_next == CAP_CNT);
    end

    assign out_valid_next = load_out || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg      <= low_next;
        high_reg     <= high_next;
        pend_low_reg <= pend_low_next;
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == $past(count_reg)) ||
                   (count_reg == $past(count_reg) + CW'(1)) ||
                   (count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_read_needs_words: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (count_reg >= CW'(2)))
        else $error("ring fetch with fewer than two words held");

    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !accept)
        else $error("transaction taken during ring fetch");

endmodule

[rtl/core/bounded_deque_engine.sv]
// Channel | Handshake               | Payload
// --------+-------------------------+--------------------------------------------
// req     | req_valid / req_stall   | dq_req_t: op, data_value
// rsp     | rsp_valid / rsp_stall   | dq_rsp_t: status, front/back, count, flags
//
// Push, reverse, query and rejected operations load the response register directly.
// A pop leaving two or more words first fetches the new end word from the
// single-read-port ring RAM, whose read data is registered, in the ST_READ state.
// Both end words are cached in registers, so only that pop needs the RAM read.
// Reset clears pointers, count, direction and response valid; RAM is not cleared.
// A stalled response blocks new requests until it is taken.
module bounded_deque_engine
    import dq_pkg::*;
#(
    parameter int CAPACITY   = DQ_CAPACITY,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  dq_req_t req,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output dq_rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    dq_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

[tb/bounded_deque_engine_tb.sv]
module bounded_deque_engine_tb;
    import dq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // op codes the block treats as a plain query
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int TOTAL_OPS = 700;

    typedef struct {
        dq_req_t req;
        int      gap;
        bit      drain;
    } op_item_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_stall;
    dq_req_t req       = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    dq_rsp_t rsp;

    // sender side
    op_item_t op_backlog[$];
    op_item_t stage;
    bit       staged    = 1'b0;
    int       idle_left = 0;
    int       sent_count = 0;
    bit       quiet_tx  = 1'b0;

    // receiver side
    dq_rsp_t  view_queue[$];
    int       stall_left = 0;
    int       mismatches = 0;
    logic     long_hold  = 1'b0;
    logic     calm_rx    = 1'b0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    int       cyc        = 0;

    // shadow of the deque
    logic [WORD_W-1:0] slot_copy [DQ_CAPACITY];
    int                head_idx   = 0;
    int                fill_level = 0;
    bit                flipped    = 1'b0;

    bounded_deque_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // apply one operation to the shadow deque and return the resulting view
    function automatic dq_rsp_t deque_apply(dq_req_t r);
        dq_rsp_t           v;
        logic [WORD_W-1:0] low_w;
        logic [WORD_W-1:0] high_w;
        v = '0;
        v.status = STAT_DONE;
        low_w = '0;
        high_w = '0;
        case (r.op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill_level == DQ_CAPACITY)
                begin
                    v.status = STAT_FULL;
                end
                else
                begin
                    if ((r.op == OP_PUSH_FRONT) != flipped)
                    begin
                        head_idx = (head_idx + DQ_CAPACITY - 1) % DQ_CAPACITY;
                        slot_copy[head_idx] = r.data_value;
                    end
                    else
                    begin
                        slot_copy[(head_idx + fill_level) % DQ_CAPACITY] = r.data_value;
                    end
                    fill_level++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill_level == 0)
                begin
                    v.status = STAT_EMPTY;
                end
                else
                begin
                    if ((r.op == OP_POP_FRONT) != flipped)
                        head_idx = (head_idx + 1) % DQ_CAPACITY;
                    fill_level--;
                end
            end
            OP_REVERSE:
                flipped = !flipped;
            default:
                ;
        endcase
        if (fill_level != 0)
        begin
            low_w  = slot_copy[head_idx];
            high_w = slot_copy[(head_idx + fill_level - 1) % DQ_CAPACITY];
        end
        v.front_value = flipped ? high_w : low_w;
        v.back_value  = flipped ? low_w : high_w;
        v.entry_count = COUNT_W'(fill_level);
        v.is_empty    = (fill_level == 0);
        v.is_full     = (fill_level == DQ_CAPACITY);
        return v;
    endfunction

    task automatic add_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                          input bit drain);
        op_item_t it;
        it.req.op         = op;
        it.req.data_value = word;
        it.gap            = quiet_tx ? 0 : $urandom_range(0, 9);
        it.drain          = drain;
        op_backlog.push_back(it);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
            begin
                view_queue.push_back(deque_apply(req));
                sent_count <= sent_count + 1;
            end
            if (!staged && op_backlog.size() != 0)
            begin
                stage     = op_backlog.pop_front();
                staged    = 1'b1;
                idle_left = stage.gap;
            end
            // a drain item waits until every owed view has come back
            if (staged && idle_left == 0 && !(stage.drain && view_queue.size() != 0))
            begin
                req_valid <= 1'b1;
                req       <= stage.req;
                staged     = 1'b0;
            end
            else
            begin
                req_valid <= 1'b0;
                if (staged && idle_left != 0)
                    idle_left--;
            end
        end
    end

    // receiver: check each transaction against the oldest owed view
    always @(posedge clk)
    begin
        dq_rsp_t exp_v;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (view_queue.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    exp_v = view_queue.pop_front();
                    if (rsp.status !== exp_v.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_v.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.front_value !== exp_v.front_value)
                    begin
                        $display("%0t: front_value exp %h got %h", $time,
                                 exp_v.front_value, rsp.front_value);
                        mismatches++;
                    end
                    if (rsp.back_value !== exp_v.back_value)
                    begin
                        $display("%0t: back_value exp %h got %h", $time,
                                 exp_v.back_value, rsp.back_value);
                        mismatches++;
                    end
                    if (rsp.entry_count !== exp_v.entry_count)
                    begin
                        $display("%0t: entry_count exp %0d got %0d", $time,
                                 exp_v.entry_count, rsp.entry_count);
                        mismatches++;
                    end
                    if (rsp.is_empty !== exp_v.is_empty)
                    begin
                        $display("%0t: is_empty exp %b got %b", $time,
                                 exp_v.is_empty, rsp.is_empty);
                        mismatches++;
                    end
                    if (rsp.is_full !== exp_v.is_full)
                    begin
                        $display("%0t: is_full exp %b got %b", $time,
                                 exp_v.is_full, rsp.is_full);
                        mismatches++;
                    end
                end
                stall_left = calm_rx ? 0 : $urandom_range(0, 9);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            rsp_stall <= (stall_left != 0) || long_hold;
        end
    end

    // long receiver hold-off once the random part is under way, plus calm stretches
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cyc       <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
            long_hold <= 1'b0;
            calm_rx   <= 1'b0;
        end
        else
        begin
            cyc     <= cyc + 1;
            calm_rx <= (cyc % 1200) >= 900;
            if (!hold_done && sent_count == 450)
            begin
                hold_done <= 1'b1;
                hold_left <= 300;
                long_hold <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                long_hold <= (hold_left > 1);
            end
        end
    end

    initial
    begin
        int n;
        int burst;
        int kind;
        int r;
        bit drained_mid;
        logic [OP_W-1:0] op;

        for (int i = 0; i < DQ_CAPACITY; i++)
            slot_copy[i] = '0;

        // directed: empty-deque corner cases, spare codes, both orders, word extremes
        add_op(OP_QUERY,      $urandom(), 1'b0);
        add_op(OP_POP_FRONT,  $urandom(), 1'b0);
        add_op(OP_POP_BACK,   $urandom(), 1'b0);
        add_op(OP_REVERSE,    $urandom(), 1'b0);
        add_op(OP_SPARE_LO,   $urandom(), 1'b0);
        add_op(OP_SPARE_HI,   $urandom(), 1'b0);
        add_op(OP_REVERSE,    $urandom(), 1'b0);
        add_op(OP_PUSH_FRONT, 32'h0000_0000, 1'b0);
        add_op(OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0);
        add_op(OP_PUSH_FRONT, 32'h8000_0001, 1'b0);
        add_op(OP_QUERY,      $urandom(), 1'b0);
        add_op(OP_REVERSE,    $urandom(), 1'b0);
        add_op(OP_POP_FRONT,  $urandom(), 1'b0);
        add_op(OP_PUSH_FRONT, 32'h7FFF_FFFE, 1'b0);
        add_op(OP_POP_BACK,   $urandom(), 1'b0);
        add_op(OP_REVERSE,    $urandom(), 1'b0);
        add_op(OP_POP_BACK,   $urandom(), 1'b0);
        add_op(OP_POP_FRONT,  $urandom(), 1'b0);
        add_op(OP_POP_FRONT,  $urandom(), 1'b0);
        add_op(OP_PUSH_BACK,  32'h5555_AAAA, 1'b0);
        add_op(OP_POP_FRONT,  $urandom(), 1'b0);
        add_op(OP_PUSH_BACK,  32'hAAAA_5555, 1'b0);
        add_op(OP_SPARE_HI,   $urandom(), 1'b0);
        add_op(OP_REVERSE,    $urandom(), 1'b0);
        add_op(OP_POP_BACK,   $urandom(), 1'b0);

        // fill to full, knock on a full deque, then empty it and knock again
        add_op(OP_QUERY, $urandom(), 1'b1);
        for (int i = 0; i < DQ_CAPACITY; i++)
            add_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word(), 1'b0);
        add_op(OP_PUSH_FRONT, $urandom(), 1'b0);
        add_op(OP_PUSH_BACK,  $urandom(), 1'b0);
        add_op(OP_REVERSE,    $urandom(), 1'b0);
        add_op(OP_PUSH_FRONT, $urandom(), 1'b0);
        add_op(OP_QUERY,      $urandom(), 1'b0);
        for (int i = 0; i < DQ_CAPACITY; i++)
            add_op($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom(), 1'b0);
        add_op(OP_POP_FRONT, $urandom(), 1'b0);
        add_op(OP_POP_BACK,  $urandom(), 1'b0);

        // random bursts leaning towards filling, draining or neither
        n = op_backlog.size();
        drained_mid = 1'b0;
        while (n < TOTAL_OPS)
        begin
            burst    = $urandom_range(20, 60);
            kind     = $urandom_range(0, 2);
            quiet_tx = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < burst && n < TOTAL_OPS; i++)
            begin
                r = $urandom_range(0, 99);
                case (kind)
                    0:       op = (r < 70) ? OP_W'($urandom_range(0, 1)) :
                                  (r < 85) ? OP_W'($urandom_range(2, 3)) :
                                             OP_W'($urandom_range(4, 7));
                    1:       op = (r < 70) ? OP_W'($urandom_range(2, 3)) :
                                  (r < 85) ? OP_W'($urandom_range(0, 1)) :
                                             OP_W'($urandom_range(4, 7));
                    default: op = OP_W'($urandom_range(0, 7));
                endcase
                add_op(op, pick_word(), !drained_mid && n >= 300 && i == 0);
                if (n >= 300 && i == 0)
                    drained_mid = 1'b1;
                n++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (op_backlog.size() != 0 || staged || req_valid)
            @(posedge clk);
        while (view_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
